### sv/stgr_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text glyph renderer package
// Shared request codes, register indexes, controller states and the
// controller-to-datapath command and status structures.
// ----------------------------------------------------------------------------
package stgr_pkg;

	localparam int unsigned GapPixels = 5;
	localparam int unsigned PosWidth  = 24;

	typedef enum logic [2:0] {
		REQ_FONT  = 3'd0,
		REQ_GLYPH = 3'd1,
		REQ_TEXT  = 3'd2,
		REQ_TICK  = 3'd3,
		REQ_PIXEL = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		REG_RED   = 3'd0,
		REG_GREEN = 3'd1,
		REG_BLUE  = 3'd2,
		REG_STEP  = 3'd3,
		REG_FIRST = 3'd4,
		REG_PAGES = 3'd5,
		REG_LEN   = 3'd6
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEXT_RD,
		ST_GLYPH_RD,
		ST_FONT_RD,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the request and clear the walk
		logic text_rd;    // issue text read for the current character
		logic glyph_rd;   // issue glyph table read
		logic font_rd;    // issue font byte read
		logic step;       // add the character's span and advance
		logic finish;     // complete tick or pixel read
	} stgr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pixel;
		logic is_tick;
		logic walk_done;  // all shown characters visited
		logic early;      // pixel read that is unlit before any walk
		logic lit_found;  // a set glyph bit was found
	} stgr_sts_t;

endpackage

### sv/stgr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stgr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/stgr_ctrl.sv
// ----------------------------------------------------------------------------
// Scrolling text renderer controller
// Sequences the per-character walk over text, glyph table and font memory.
// ----------------------------------------------------------------------------
module stgr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output stgr_pkg::stgr_cmd_t cmd,
	input  stgr_pkg::stgr_sts_t sts
);
	import stgr_pkg::*;

	state_t state_q, state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.is_pixel && !sts.is_tick) state_nx = ST_IDLE;
				else if (sts.early || sts.walk_done || sts.lit_found) state_nx = ST_FINISH;
				else state_nx = ST_TEXT_RD;
			end
			ST_TEXT_RD:  state_nx = ST_GLYPH_RD;
			ST_GLYPH_RD: state_nx = ST_FONT_RD;
			ST_FONT_RD:  state_nx = ST_CHECK;
			ST_FINISH:   state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     cmd.load = start;
			ST_CHECK: begin
				if ((sts.is_pixel || sts.is_tick) && !sts.early && !sts.walk_done
						&& !sts.lit_found) begin
					cmd.text_rd = 1'b1;
				end
			end
			ST_TEXT_RD:  cmd.glyph_rd = 1'b1;
			ST_GLYPH_RD: cmd.font_rd = 1'b1;
			ST_FONT_RD:  cmd.step = 1'b1;
			ST_FINISH:   cmd.finish = 1'b1;
			default:     cmd = '0;
		endcase
	end
endmodule

### sv/stgr_dp.sv
// ----------------------------------------------------------------------------
// Scrolling text renderer datapath
// Holds the stores, configuration, scroll position and the walk registers.
// ----------------------------------------------------------------------------
module stgr_dp #(
	parameter int unsigned DISPLAY_WIDTH  = 64,
	parameter int unsigned DISPLAY_HEIGHT = 16,
	parameter int unsigned TEXT_DEPTH     = 64,
	parameter int unsigned GLYPH_COUNT    = 128,
	parameter int unsigned FONT_BYTES     = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stgr_pkg::stgr_cmd_t cmd,
	output stgr_pkg::stgr_sts_t sts,
	input  logic [2:0]          req_type,
	input  logic [11:0]         index,
	input  logic [7:0]          data_byte,
	input  logic [11:0]         glyph_start,
	input  logic [5:0]          glyph_width,
	input  logic [5:0]          pixel_x,
	input  logic [3:0]          pixel_y,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata,
	output logic                strobe,
	output logic                lit,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);
	import stgr_pkg::*;

	localparam int unsigned TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int unsigned GAW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int unsigned FAW = $clog2(FONT_BYTES);
	localparam int unsigned CW  = $clog2(TEXT_DEPTH + 1);
	// Character x positions in whole pixels, wide enough for any span.
	localparam int unsigned XW  = 18;

	// Configuration registers.
	logic [7:0]  red_q, green_q, blue_q, first_q;
	logic [15:0] step_q;
	logic [2:0]  pages_q;
	logic [6:0]  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			step_q  <= '0;
			first_q <= 8'd32;
			pages_q <= 3'd2;
			len_q   <= '0;
		end else if (cfg_we) begin
			case (reg_t'(cfg_idx))
				REG_RED:   red_q   <= cfg_wdata[7:0];
				REG_GREEN: green_q <= cfg_wdata[7:0];
				REG_BLUE:  blue_q  <= cfg_wdata[7:0];
				REG_STEP:  step_q  <= cfg_wdata;
				REG_FIRST: first_q <= cfg_wdata[7:0];
				REG_PAGES: pages_q <= cfg_wdata[2:0];
				REG_LEN:   len_q   <= cfg_wdata[6:0];
				default:   ;
			endcase
		end
	end

	// Captured request.
	logic [2:0]  type_q;
	logic [5:0]  px_q;
	logic [3:0]  py_q;
	logic        early_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			px_q   <= pixel_x;
			py_q   <= pixel_y;
		end
	end

	// A pixel outside the panel or below the glyph rows is unlit at once.
	logic [6:0] rows;
	always_comb begin
		rows = {1'b0, pages_q, 3'b000};
		if (rows > 7'(DISPLAY_HEIGHT)) rows = 7'(DISPLAY_HEIGHT);
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			early_q <= (32'(pixel_x) >= DISPLAY_WIDTH) || (32'(pixel_y) >= DISPLAY_HEIGHT)
				|| ({3'b000, pixel_y} >= rows);
		end
	end

	// Memory writes are taken at request acceptance.
	logic f_we, g_we, t_we;
	assign f_we = cmd.load && req_type == REQ_FONT  && 32'(index) < FONT_BYTES;
	assign g_we = cmd.load && req_type == REQ_GLYPH && 32'(index) < GLYPH_COUNT;
	assign t_we = cmd.load && req_type == REQ_TEXT  && 32'(index) < TEXT_DEPTH;

	// Walk registers.
	logic [CW-1:0]  cnt_q;
	logic [XW-1:0]  x_q;     // start x of current character (two's complement)
	logic [XW-1:0]  span_q;  // running span in pixels
	logic           found_q;
	logic [7:0]     t_rd;
	logic [17:0]    g_rd;
	logic [7:0]     f_rd;
	logic [FAW-1:0] f_raddr;
	logic           has_g_s1;
	logic [5:0]     gw_s2;
	logic           hit_s2;
	logic [2:0]     bit_s2;
	logic [8:0]     ent;

	stgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
		.clk(clk), .we(f_we), .waddr(index[FAW-1:0]), .wdata(data_byte),
		.raddr(f_raddr), .rdata(f_rd));
	stgr_ram #(.WIDTH(18), .DEPTH(GLYPH_COUNT)) u_glyph (
		.clk(clk), .we(g_we), .waddr(index[GAW-1:0]),
		.wdata({glyph_width, glyph_start}), .raddr(ent[GAW-1:0]), .rdata(g_rd));
	stgr_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
		.clk(clk), .we(t_we), .waddr(index[TAW-1:0]), .wdata(data_byte),
		.raddr(cnt_q[TAW-1:0]), .rdata(t_rd));

	// Number of characters shown.
	logic [CW-1:0] shown;
	assign shown = (32'(len_q) > TEXT_DEPTH) ? CW'(TEXT_DEPTH) : CW'(len_q);

	// Whole-pixel draw offset, truncated toward zero.
	logic signed [PosWidth-1:0] pos_q;
	logic [PosWidth-1:0]        pos_abs;
	logic [XW-1:0]              off;
	assign pos_abs = pos_q[PosWidth-1] ? PosWidth'(-pos_q) : pos_q;
	assign off = pos_q[PosWidth-1] ? XW'(-$signed({2'b00, pos_abs[PosWidth-1:8]}))
		: XW'({2'b00, pos_abs[PosWidth-1:8]});

	// Glyph lookup on the character read from text memory.
	logic       has_g;
	assign ent = {1'b0, t_rd} - {1'b0, first_q};
	assign has_g = !ent[8] && 32'(ent[7:0]) < GLYPH_COUNT;

	// Font address and column test for the current character.
	logic [5:0]    gw;
	logic [3:0]    nb;
	logic [XW-1:0] rel;
	logic          in_col;
	assign gw = has_g_s1 ? g_rd[17:12] : 6'd0;
	assign nb = 4'((7'(gw) + 7'd7) >> 3);
	assign rel = 18'({2'b00, px_q}) - x_q;
	assign in_col = has_g_s1 && !rel[XW-1] && rel < XW'({nb, 3'b000});
	assign f_raddr = FAW'(g_rd[11:0] + 12'(py_q) * 12'(nb) + 12'(rel[XW-1:3]));

	always_ff @(posedge clk) begin
		if (cmd.glyph_rd) has_g_s1 <= has_g;
		if (cmd.font_rd) begin
			gw_s2  <= gw;
			hit_s2 <= in_col;
			bit_s2 <= rel[2:0];
		end
	end

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			x_q     <= '0;
			span_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			x_q     <= off;
			span_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			cnt_q   <= cnt_q + 1'b1;
			x_q     <= x_q + XW'(gw_s2) + XW'(GapPixels);
			span_q  <= span_q + XW'(gw_s2) + XW'(GapPixels);
			if (type_q == REQ_PIXEL && hit_s2 && f_rd[3'd7 - bit_s2]) found_q <= 1'b1;
		end
	end

	// Scroll position update.
	logic signed [PosWidth-1:0] np;
	logic signed [PosWidth+2:0] lim;
	assign np = pos_q - PosWidth'($signed(step_q));
	assign lim = -$signed({1'b0, span_q, 8'h00});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (t_we) begin
			pos_q <= '0;
		end else if (cmd.finish && type_q == REQ_TICK) begin
			pos_q <= ((PosWidth+3)'(np) <= lim) ? '0 : np;
		end
	end

	assign sts.is_pixel  = type_q == REQ_PIXEL;
	assign sts.is_tick   = type_q == REQ_TICK;
	assign sts.walk_done = cnt_q >= shown;
	assign sts.early     = type_q == REQ_PIXEL && early_q;
	assign sts.lit_found = found_q;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.finish && type_q == REQ_PIXEL;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			lit   <= found_q;
			red   <= found_q ? red_q : 8'd0;
			green <= found_q ? green_q : 8'd0;
			blue  <= found_q ? blue_q : 8'd0;
		end
	end
endmodule

### sv/scrolling_text_glyph_renderer.sv
// ----------------------------------------------------------------------------
// Scrolling text glyph renderer
// A request is accepted on a rising edge with start high and busy low.
// req_type selects a font byte write, glyph entry write, text character
// write, frame tick or pixel read. A write keeps busy high only while the
// controller checks the request type before it returns to idle.
// A tick or pixel read walks the n = min(text_length, TEXT_DEPTH) shown
// characters, each through text memory, glyph table, font memory and
// accumulate steps, and busy stays high until the walk ends. A pixel read
// stops after the character holding the first lit bit; a pixel outside
// the panel or below the glyph rows ends without a walk.
// The pixel read result appears for one cycle with strobe high, in the
// first cycle after busy drops. The receiver cannot stall.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high.
// Reset zeroes scroll position and registers, but sets first 32, pages 2;
// the font, glyph and text memories hold nothing defined until written.
// ----------------------------------------------------------------------------
module scrolling_text_glyph_renderer #(
	parameter int unsigned DISPLAY_WIDTH  = 64,
	parameter int unsigned DISPLAY_HEIGHT = 16,
	parameter int unsigned TEXT_DEPTH     = 64,
	parameter int unsigned GLYPH_COUNT    = 128,
	parameter int unsigned FONT_BYTES     = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [11:0] index,
	input  logic [7:0]  data_byte,
	input  logic [11:0] glyph_start,
	input  logic [5:0]  glyph_width,
	input  logic [5:0]  pixel_x,
	input  logic [3:0]  pixel_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic        lit,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import stgr_pkg::*;

	stgr_cmd_t cmd;
	stgr_sts_t sts;

	assign cfg_ready = 1'b1;

	stgr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts));

	stgr_dp #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
		.TEXT_DEPTH(TEXT_DEPTH), .GLYPH_COUNT(GLYPH_COUNT), .FONT_BYTES(FONT_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .index(index), .data_byte(data_byte),
		.glyph_start(glyph_start), .glyph_width(glyph_width),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.strobe(strobe), .lit(lit), .red(red), .green(green), .blue(blue));

`ifndef NO_ASSERTIONS
	// A result only follows a finishing step of the controller.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(cmd.finish)) else $error("strobe without finish");
	// An unlit result carries black.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !lit) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("unlit pixel not black");
	// Only one controller command is active at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("multiple commands");
`endif
endmodule

### dv/stgr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling text glyph renderer checker
// Watches the request, configuration and result channels of the renderer,
// keeps its own copy of the font, glyph and text stores, the scroll position
// and the registers, predicts every pixel read and compares the strobed
// results field by field in order.
// ----------------------------------------------------------------------------
module stgr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [11:0] index,
	input  logic [7:0]  data_byte,
	input  logic [11:0] glyph_start,
	input  logic [5:0]  glyph_width,
	input  logic [5:0]  pixel_x,
	input  logic [3:0]  pixel_y,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        strobe,
	input  logic        lit,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output int          pending,
	output int          errors
);
	import stgr_pkg::*;

	typedef struct packed {
		logic       lit;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	pixel_t pixel_q[$];

	// Mirrored stores and registers.
	logic [7:0]         font_mem [4096];
	logic [17:0]        glyph_mem [128];
	logic [7:0]         text_mem [64];
	logic signed [23:0] scroll_pos;
	logic [7:0]         col_r, col_g, col_b;
	logic signed [15:0] step_r;
	logic [7:0]         first_r;
	logic [2:0]         pages_r;
	logic [6:0]         len_r;

	assign pending = pixel_q.size();

	function automatic int shown();
		return (len_r > 64) ? 64 : int'(len_r);
	endfunction

	// Looks up a character's glyph; returns 0 when it has none.
	function automatic bit glyph_for(input logic [7:0] code, output int gs, output int gw);
		int e;
		gs = 0;
		gw = 0;
		if (code < first_r) return 0;
		e = int'(code) - int'(first_r);
		if (e >= 128) return 0;
		gs = int'(glyph_mem[e][11:0]);
		gw = int'(glyph_mem[e][17:12]);
		return 1;
	endfunction

	function automatic longint text_span();
		longint s;
		int gs, gw;
		s = 0;
		for (int i = 0; i < shown(); i++) begin
			if (!glyph_for(text_mem[i], gs, gw)) gw = 0;
			s += gw + GapPixels;
		end
		return s;
	endfunction

	function automatic bit pixel_covered(input int px, input int py);
		int rows, gs, gw, nb, r, addr;
		longint sx, rel;
		rows = int'(pages_r) * 8;
		if (rows > 16) rows = 16;
		if (px >= 64 || py >= rows) return 0;
		// Signed division truncates toward zero, as the draw offset requires.
		sx = longint'(scroll_pos) / 256;
		for (int i = 0; i < shown(); i++) begin
			if (glyph_for(text_mem[i], gs, gw)) begin
				nb = (gw + 7) / 8;
				rel = px - sx;
				if (rel >= 0 && rel < nb * 8) begin
					r = int'(rel);
					addr = (gs + py * nb + r / 8) % 4096;
					if (font_mem[addr][7 - (r % 8)]) return 1;
				end
			end else begin
				gw = 0;
			end
			sx += gw + GapPixels;
		end
		return 0;
	endfunction

	// Predict on every accepted request and configuration write.
	always @(posedge clk or negedge arst_n) begin
		logic signed [23:0] np;
		pixel_t exp_px;
		if (!arst_n) begin
			scroll_pos <= '0;
			col_r <= '0;
			col_g <= '0;
			col_b <= '0;
			step_r <= '0;
			first_r <= 8'd32;
			pages_r <= 3'd2;
			len_r <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_t'(cfg_index))
					REG_RED:   col_r <= cfg_data[7:0];
					REG_GREEN: col_g <= cfg_data[7:0];
					REG_BLUE:  col_b <= cfg_data[7:0];
					REG_STEP:  step_r <= cfg_data;
					REG_FIRST: first_r <= cfg_data[7:0];
					REG_PAGES: pages_r <= cfg_data[2:0];
					REG_LEN:   len_r <= cfg_data[6:0];
					default:   ;
				endcase
			end
			if (start && !busy) begin
				case (req_type)
					REQ_FONT: font_mem[index] <= data_byte;
					REQ_GLYPH: begin
						if (index < 128) glyph_mem[index] <= {glyph_width, glyph_start};
					end
					REQ_TEXT: begin
						if (index < 64) begin
							text_mem[index] <= data_byte;
							scroll_pos <= '0;
						end
					end
					REQ_TICK: begin
						np = scroll_pos - step_r;
						if (longint'(np) <= -(text_span() * 256)) np = '0;
						scroll_pos <= np;
					end
					REQ_PIXEL: begin
						exp_px.lit = pixel_covered(int'(pixel_x), int'(pixel_y));
						exp_px.red = exp_px.lit ? col_r : 8'd0;
						exp_px.green = exp_px.lit ? col_g : 8'd0;
						exp_px.blue = exp_px.lit ? col_b : 8'd0;
						pixel_q.push_back(exp_px);
					end
					default: ;
				endcase
			end
		end
	end

	// Compare each strobed result with the oldest expectation.
	initial errors = 0;
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && strobe) begin
			if (pixel_q.size() == 0) begin
				$display("%0t: result with nothing expected: lit %0b rgb %02x %02x %02x",
					$time, lit, red, green, blue);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (lit !== want.lit) begin
					$display("%0t: lit expected %0b actual %0b", $time, want.lit, lit);
					errors++;
				end
				if (red !== want.red) begin
					$display("%0t: red expected %02x actual %02x", $time, want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$display("%0t: green expected %02x actual %02x", $time, want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$display("%0t: blue expected %02x actual %02x", $time, want.blue, blue);
					errors++;
				end
			end
		end
	end

endmodule

### dv/tb_scrolling_text_glyph_renderer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling text glyph renderer testbench
// Fills the font, glyph and text stores, runs a directed set of requests and
// then random requests over several register settings, with random gaps and
// a drain between settings. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_scrolling_text_glyph_renderer;
	import stgr_pkg::*;

	localparam int SettleCycles = 300;
	// Glyphs start low enough that all their rows stay inside the filled font.
	localparam int FontFill      = 512;
	localparam int MaxGlyphStart = 447;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [11:0] index = '0;
	logic [7:0]  data_byte = '0;
	logic [11:0] glyph_start = '0;
	logic [5:0]  glyph_width = '0;
	logic [5:0]  pixel_x = '0;
	logic [3:0]  pixel_y = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        strobe, lit;
	logic [7:0]  red, green, blue;
	int          pending, errors;
	int          sent_count = 0, read_count = 0;

	always #5 clk = ~clk;

	scrolling_text_glyph_renderer i_dut (.*);

	stgr_checker i_checker (.*);

	// Present one request after a random gap; start stays high on return.
	task automatic send(input logic [2:0] kind, input int idx, input int dat,
			input int gs, input int gw, input int px, input int py, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= kind;
		index <= 12'(idx);
		data_byte <= 8'(dat);
		glyph_start <= 12'(gs);
		glyph_width <= 6'(gw);
		pixel_x <= 6'(px);
		pixel_y <= 4'(py);
		start <= 1'b1;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent_count++;
		if (kind == REQ_PIXEL) read_count++;
	endtask

	task automatic pixel(input int px, input int py);
		send(REQ_PIXEL, 0, 0, 0, 0, px, py, 0);
	endtask

	// Pause the sender until every pixel read has returned and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes back to back keep valid high; the caller drops it after the last.
	task automatic write_reg(input reg_t r, input int value);
		cfg_index <= r;
		cfg_data <= 16'(value);
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic setup(input int rgb, input int stp, input int first, input int pages,
			input int len);
		write_reg(REG_RED, rgb[23:16]);
		write_reg(REG_GREEN, rgb[15:8]);
		write_reg(REG_BLUE, rgb[7:0]);
		write_reg(REG_STEP, stp);
		write_reg(REG_FIRST, first);
		write_reg(REG_PAGES, pages);
		write_reg(REG_LEN, len);
		cfg_valid <= 1'b0;
	endtask

	// One random request, weighted toward reads and ticks.
	task automatic random_request(input int first);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			pixel($urandom_range(0, 63), $urandom_range(0, 15));
		else if (pick < 70)
			send(REQ_TICK, $urandom, 0, 0, 0, 0, 0, 0);
		else if (pick < 79)
			send(REQ_FONT, $urandom_range(0, 4095), $urandom, 0, 0, 0, 0, 0);
		else if (pick < 88)
			send(REQ_GLYPH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
				$urandom_range(0, 127), 0, $urandom_range(0, MaxGlyphStart),
				$urandom_range(0, 32), 0, 0, 0);
		else if (pick < 93)
			send(REQ_TEXT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
				$urandom_range(0, 63), ($urandom_range(0, 3) == 0) ? $urandom :
				first + $urandom_range(0, 140), 0, 0, 0, 0, 0);
		else
			send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, 0);
	endtask

	// Stimulus.
	initial begin
		int rgb, stp, first, pages, len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every store entry that a read can reach.
		for (int a = 0; a < FontFill; a++)
			send(REQ_FONT, a, $urandom, 0, 0, 0, 0, $urandom_range(0, 7) != 0);
		for (int g = 0; g < 128; g++)
			send(REQ_GLYPH, g, 0, $urandom_range(0, MaxGlyphStart), $urandom_range(0, 32),
				0, 0, 1);
		for (int t = 0; t < 64; t++)
			send(REQ_TEXT, t, 32 + $urandom_range(0, 127), 0, 0, 0, 0, 1);
		pixel(0, 0);
		drain();

		// Directed requests: extremes, blank glyphs, ignored writes and codes.
		setup(24'hFF00AA, 256, 32, 2, 4);
		pixel(0, 0);
		pixel(63, 15);
		send(REQ_GLYPH, 127, 0, 4095, 32, 0, 0, 0);
		send(REQ_GLYPH, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_GLYPH, 4095, 0, 123, 7, 0, 0, 0);
		send(REQ_TEXT, 0, 31, 0, 0, 0, 0, 0);
		send(REQ_TEXT, 1, 32, 0, 0, 0, 0, 0);
		send(REQ_TEXT, 2, 159, 0, 0, 0, 0, 0);
		send(REQ_TEXT, 63, 255, 0, 0, 0, 0, 0);
		send(REQ_TEXT, 64, 65, 0, 0, 0, 0, 0);
		send(REQ_FONT, 4095, 255, 0, 0, 0, 0, 0);
		pixel(3, 7);
		send(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		pixel(0, 8);
		send(3'd5, 4095, 255, 4095, 63, 63, 15, 0);
		send(3'd6, 0, 0, 0, 0, 0, 0, 0);
		send(3'd7, 0, 0, 0, 0, 0, 0, 0);
		pixel(10, 15);
		drain();
		// Empty text: a tick resets the position only when the new one is not positive.
		setup(24'h123456, -32768, 32, 1, 0);
		send(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);
		pixel(0, 0);
		pixel(5, 9);
		drain();

		// Random phases over a spread of settings, extremes included.
		for (int ph = 0; ph < 12; ph++) begin
			rgb = (ph == 0) ? 24'hFFFFFF : (ph == 1) ? 24'h000000 : $urandom;
			case (ph % 6)
				0: stp = 32767;
				1: stp = -32768;
				2: stp = 0;
				default: stp = $urandom_range(0, 4096) - 1024;
			endcase
			first = (ph == 2) ? 0 : (ph == 3) ? 255 : (ph % 2) ? 32 : $urandom_range(0, 96);
			pages = 1 + (ph % 4);
			case (ph)
				4: len = 64;
				5: len = 127;
				6: len = 0;
				default: len = $urandom_range(1, 8);
			endcase
			setup(rgb, stp, first, pages, len);
			for (int n = 0; n < ((len > 8) ? 60 : 110); n++) random_request(first);
			drain();
		end

		start <= 1'b0;
		$display("Sent %0d requests including %0d pixel reads across 14 register settings.",
			sent_count, read_count);
		$display("Stores were filled, then ticks, writes, blank glyphs and ignored codes mixed.");
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#100ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
